// ===== rtl/tlpp_pkg.sv =====
// Shared types and constants for the three-level task picker.
// Used by three_level_process_picker_unit; depends on nothing.
package tlpp_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam logic [31:0] AGING_RESET = 32'd8000;
  localparam logic [15:0] WEIGHT_ONE = 16'd256;
  localparam logic [15:0] RUNS_MAX = 16'hFFFF;
  localparam int RANK_W = 54;

  // item modes
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_WEIGHT = 2'd1;
  localparam logic [1:0] MODE_AGE    = 2'd2;
  localparam logic [1:0] MODE_PICK   = 2'd3;

  // queue codes
  localparam logic [1:0] Q_NONE = 2'd0;
  localparam logic [1:0] Q_RR   = 2'd1;
  localparam logic [1:0] Q_LCFS = 2'd2;
  localparam logic [1:0] Q_BEST = 2'd3;

  // reported policy
  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_LCFS = 2'd1;
  localparam logic [1:0] POL_BEST = 2'd2;

  // register byte address of aging_limit
  localparam logic [2:0] ADDR_AGING = 3'd0;

  typedef struct packed {
    logic        ready;
    logic [1:0]  queue;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [31:0] served_at;
    logic [15:0] runs;
    logic [15:0] pw;
    logic [15:0] aw;
    logic [15:0] rw;
  } slot_rec_t;

  localparam slot_rec_t REC_RESET = '{
    ready: 1'b0, queue: Q_NONE, prio: 8'd0, arrival: 32'd0, served_at: 32'd0,
    runs: 16'd0, pw: WEIGHT_ONE, aw: WEIGHT_ONE, rw: WEIGHT_ONE};

  typedef enum logic [2:0] {
    S_IDLE, S_RMW_RD, S_RMW_WR, S_SCAN, S_FIX_RD, S_FIX_WR, S_DONE
  } state_t;

endpackage

// ===== rtl/tlpp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module tlpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/three_level_process_picker_unit.sv =====
// Three-level task picker: slot table in one RAM, scanned one slot a cycle.
// Write and single-weight items read, modify and write back one slot. Age, broadcast
// and pick items scan every slot through the single RAM read port, and pick then
// reads and writes back the chosen slot. One item at a time.
// Reset (rst_n, synchronous) clears per-slot valid bits, so every slot reads as its
// reset record at once; no clearing pass. Depends on tlpp_pkg and tlpp_ram.
module three_level_process_picker_unit #(
  parameter int NUM_SLOTS = tlpp_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_slot,
  input  logic        in_runnable,
  input  logic [1:0]  in_queue_sel,
  input  logic [7:0]  in_priority_req,
  input  logic        in_fresh,
  input  logic [31:0] in_now,
  input  logic [15:0] in_priority_weight,
  input  logic [15:0] in_arrival_weight,
  input  logic [15:0] in_run_weight,
  input  logic        in_broadcast,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [5:0]  out_chosen_slot,
  output logic [1:0]  out_chosen_policy,
  output logic [6:0]  out_moved_count,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = SW + 1;
  localparam int RW = $bits(tlpp_pkg::slot_rec_t);

  tlpp_pkg::state_t state_r, state_nxt;

  // captured item
  logic [1:0]  mode_r;
  logic [5:0]  slot_r;
  logic        runnable_r, fresh_r;
  logic [1:0]  qsel_r;
  logic [7:0]  prio_r;
  logic [31:0] now_r;
  logic [15:0] pw_r, aw_r, rw_r;

  logic [31:0] aging_limit_r;
  logic [SW-1:0] last_rr_r;
  logic [NUM_SLOTS-1:0] vld_r;
  logic rd_vld_r;

  // scan pipeline
  logic [CW-1:0] scan_cnt_r;
  logic p1_v_r, p2_v_r, p3_v_r, b2_r, b3_r;
  logic [SW-1:0] idx1_r, idx2_r, idx3_r;
  logic [23:0] pp_r;
  logic [47:0] ap_r;
  logic [31:0] rp_r;
  logic [tlpp_pkg::RANK_W-1:0] rank3_r;

  // candidates
  logic rr_hi_f_r, rr_lo_f_r, lc_f_r, be_f_r;
  logic [SW-1:0] rr_hi_r, rr_lo_r, lc_idx_r, be_idx_r;
  logic [31:0] lc_best_r;
  logic [tlpp_pkg::RANK_W-1:0] be_best_r;
  logic [CW-1:0] moved_r;

  logic hit_r;
  logic [SW-1:0] pick_idx_r;
  logic [1:0] pol_r;

  // output register
  logic       out_valid_r, found_r;
  logic [5:0] chosen_r;
  logic [1:0] policy_r;
  logic [6:0] moved_out_r;

  // RAM port
  logic ram_we;
  logic [SW-1:0] ram_waddr, ram_raddr;
  tlpp_pkg::slot_rec_t ram_wrec, rec_q;
  logic [RW-1:0] ram_rdata;

  logic in_acc, issue, scan_end, out_load, in_slot_ok, aged;
  logic best_hit, pick_hit;
  logic [SW-1:0] pick_idx;
  logic [1:0] pick_pol;
  logic [48:0] psum;
  logic [tlpp_pkg::RANK_W-1:0] rank_nxt;
  logic [SW-1:0] slot_addr;

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != tlpp_pkg::S_IDLE);
  assign in_slot_ok = ({26'd0, in_slot} < 32'(NUM_SLOTS));
  assign slot_addr  = SW'(slot_r);
  assign issue      = (state_r == tlpp_pkg::S_SCAN) && (scan_cnt_r < CW'(NUM_SLOTS));
  assign scan_end   = (state_r == tlpp_pkg::S_SCAN) && !issue && !p1_v_r && !p2_v_r
                      && !p3_v_r;
  assign out_load   = (state_r == tlpp_pkg::S_DONE) && (!out_valid_r || !out_stall);
  assign rec_q      = rd_vld_r ? tlpp_pkg::slot_rec_t'(ram_rdata) : tlpp_pkg::REC_RESET;
  assign aged       = rec_q.ready && (rec_q.queue != tlpp_pkg::Q_RR)
                      && ((now_r - rec_q.served_at) > aging_limit_r);

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == tlpp_pkg::ADDR_AGING[2]) ? aging_limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_limit_r <= tlpp_pkg::AGING_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == tlpp_pkg::ADDR_AGING[2]) begin
      aging_limit_r <= pwdata;
    end
  end

  // final choice: round robin after last, then wrapped, then LCFS, then best job
  always_comb begin
    pick_hit = 1'b1;
    pick_idx = rr_hi_r;
    pick_pol = tlpp_pkg::POL_RR;
    if (rr_hi_f_r) begin
      pick_idx = rr_hi_r;
    end else if (rr_lo_f_r) begin
      pick_idx = rr_lo_r;
    end else if (lc_f_r) begin
      pick_idx = lc_idx_r;
      pick_pol = tlpp_pkg::POL_LCFS;
    end else if (be_f_r) begin
      pick_idx = be_idx_r;
      pick_pol = tlpp_pkg::POL_BEST;
    end else begin
      pick_hit = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlpp_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_mode == tlpp_pkg::MODE_AGE || in_mode == tlpp_pkg::MODE_PICK
              || (in_mode == tlpp_pkg::MODE_WEIGHT && in_broadcast)) begin
            state_nxt = tlpp_pkg::S_SCAN;
          end else if (in_slot_ok) begin
            state_nxt = tlpp_pkg::S_RMW_RD;
          end else begin
            state_nxt = tlpp_pkg::S_DONE;
          end
        end
      end
      tlpp_pkg::S_RMW_RD: state_nxt = tlpp_pkg::S_RMW_WR;
      tlpp_pkg::S_RMW_WR: state_nxt = tlpp_pkg::S_DONE;
      tlpp_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = (mode_r == tlpp_pkg::MODE_PICK && pick_hit) ? tlpp_pkg::S_FIX_RD
                                                                  : tlpp_pkg::S_DONE;
        end
      end
      tlpp_pkg::S_FIX_RD: state_nxt = tlpp_pkg::S_FIX_WR;
      tlpp_pkg::S_FIX_WR: state_nxt = tlpp_pkg::S_DONE;
      tlpp_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = tlpp_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlpp_pkg::S_IDLE;
    endcase
  end

  // RAM controls per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx1_r;
    ram_raddr = scan_cnt_r[SW-1:0];
    ram_wrec  = rec_q;
    case (state_r)
      tlpp_pkg::S_RMW_RD: ram_raddr = slot_addr;
      tlpp_pkg::S_RMW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr;
        if (mode_r == tlpp_pkg::MODE_WRITE) begin
          ram_wrec.ready = runnable_r;
          ram_wrec.queue = qsel_r;
          ram_wrec.prio  = prio_r;
          if (fresh_r) begin
            ram_wrec.arrival   = now_r;
            ram_wrec.served_at = now_r;
            ram_wrec.runs      = 16'd0;
            ram_wrec.pw        = tlpp_pkg::WEIGHT_ONE;
            ram_wrec.aw        = tlpp_pkg::WEIGHT_ONE;
            ram_wrec.rw        = tlpp_pkg::WEIGHT_ONE;
          end
        end else begin
          ram_wrec.pw = pw_r;
          ram_wrec.aw = aw_r;
          ram_wrec.rw = rw_r;
        end
      end
      tlpp_pkg::S_SCAN: begin
        ram_we = p1_v_r && (mode_r == tlpp_pkg::MODE_AGE || mode_r == tlpp_pkg::MODE_WEIGHT);
        if (mode_r == tlpp_pkg::MODE_AGE) begin
          if (aged) begin
            ram_wrec.queue = tlpp_pkg::Q_RR;
          end
        end else begin
          ram_wrec.pw = pw_r;
          ram_wrec.aw = aw_r;
          ram_wrec.rw = rw_r;
        end
      end
      tlpp_pkg::S_FIX_RD: ram_raddr = pick_idx_r;
      tlpp_pkg::S_FIX_WR: begin
        ram_we             = 1'b1;
        ram_waddr          = pick_idx_r;
        ram_wrec.ready     = 1'b0;
        ram_wrec.served_at = now_r;
        if (rec_q.runs != tlpp_pkg::RUNS_MAX) begin
          ram_wrec.runs = rec_q.runs + 16'd1;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  tlpp_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // rank pipeline arithmetic: 10*(p*pw + a*aw) + runs*rw
  assign psum     = {25'd0, pp_r} + {1'b0, ap_r};
  assign rank_nxt = {2'b0, psum, 3'b0} + {4'b0, psum, 1'b0} + {22'd0, rp_r};
  assign best_hit = p1_v_r && (mode_r == tlpp_pkg::MODE_PICK) && rec_q.ready
                    && (rec_q.queue == tlpp_pkg::Q_BEST);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpp_pkg::S_IDLE;
      vld_r       <= '0;
      last_rr_r   <= SW'(NUM_SLOTS - 1);
      out_valid_r <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (state_r == tlpp_pkg::S_FIX_WR && pol_r == tlpp_pkg::POL_RR) begin
        last_rr_r <= pick_idx_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  // item capture, scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[ram_raddr];
    if (in_acc) begin
      mode_r     <= in_mode;
      slot_r     <= in_slot;
      runnable_r <= in_runnable;
      qsel_r     <= in_queue_sel;
      prio_r     <= in_priority_req;
      fresh_r    <= in_fresh;
      now_r      <= in_now;
      pw_r       <= in_priority_weight;
      aw_r       <= in_arrival_weight;
      rw_r       <= in_run_weight;
      scan_cnt_r <= '0;
      rr_hi_f_r  <= 1'b0;
      rr_lo_f_r  <= 1'b0;
      lc_f_r     <= 1'b0;
      be_f_r     <= 1'b0;
      moved_r    <= '0;
      hit_r      <= 1'b0;
    end
    if (issue) begin
      scan_cnt_r <= scan_cnt_r + CW'(1);
    end
    idx1_r <= scan_cnt_r[SW-1:0];
    // stage 1: round robin, LCFS, aging count
    if (p1_v_r && mode_r == tlpp_pkg::MODE_PICK && rec_q.ready) begin
      if (rec_q.queue == tlpp_pkg::Q_RR) begin
        if (idx1_r > last_rr_r) begin
          if (!rr_hi_f_r) begin
            rr_hi_f_r <= 1'b1;
            rr_hi_r   <= idx1_r;
          end
        end else if (!rr_lo_f_r) begin
          rr_lo_f_r <= 1'b1;
          rr_lo_r   <= idx1_r;
        end
      end
      if (rec_q.queue == tlpp_pkg::Q_LCFS && (!lc_f_r || rec_q.arrival > lc_best_r)) begin
        lc_f_r    <= 1'b1;
        lc_idx_r  <= idx1_r;
        lc_best_r <= rec_q.arrival;
      end
    end
    if (p1_v_r && mode_r == tlpp_pkg::MODE_AGE && aged) begin
      moved_r <= moved_r + CW'(1);
    end
    // stage 2: products
    pp_r   <= rec_q.prio * rec_q.pw;
    ap_r   <= rec_q.arrival * rec_q.aw;
    rp_r   <= rec_q.runs * rec_q.rw;
    b2_r   <= best_hit;
    idx2_r <= idx1_r;
    // stage 3: rank
    rank3_r <= rank_nxt;
    b3_r    <= p2_v_r && b2_r;
    idx3_r  <= idx2_r;
    // best job compare
    if (p3_v_r && b3_r && (!be_f_r || rank3_r < be_best_r)) begin
      be_f_r    <= 1'b1;
      be_idx_r  <= idx3_r;
      be_best_r <= rank3_r;
    end
    if (scan_end && mode_r == tlpp_pkg::MODE_PICK) begin
      hit_r      <= pick_hit;
      pick_idx_r <= pick_idx;
      pol_r      <= pick_pol;
    end
    if (out_load) begin
      found_r     <= hit_r;
      chosen_r    <= hit_r ? 6'(pick_idx_r) : 6'd0;
      policy_r    <= hit_r ? pol_r : tlpp_pkg::POL_RR;
      moved_out_r <= 7'(moved_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_chosen_slot   = chosen_r;
  assign out_chosen_policy = policy_r;
  assign out_moved_count   = moved_out_r;

`ifndef SYNTHESIS
  // table is only written while an item is being worked
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tlpp_pkg::S_IDLE |-> !ram_we)
    else $error("table written while idle");

  // a new result is only raised from the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == tlpp_pkg::S_DONE)
    else $error("result raised outside done state");

  // no pick: slot and policy read zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> chosen_r == 6'd0 && policy_r == tlpp_pkg::POL_RR)
    else $error("miss result carries slot or policy");

  // aging count never passes the table size
  a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tlpp_pkg::S_SCAN |-> moved_r <= CW'(NUM_SLOTS))
    else $error("moved count overflow");
`endif

endmodule
